>>> src/mfl_pkg.sv
`default_nettype none
package mfl_pkg;

  localparam int unsigned FrameDepth = 32;
  localparam int unsigned IdxW = $clog2(FrameDepth);
  localparam int unsigned CntW = $clog2(FrameDepth + 1);
  localparam int unsigned TmoW = 21;
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW = $clog2(QDepth);
  localparam int unsigned QCntW = $clog2(QDepth + 1);
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgTimeout = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgSeed = 1'b1;

  typedef enum logic [2:0] {
    ActStart      = 3'd0,
    ActTxByte     = 3'd1,
    ActRxWord     = 3'd2,
    ActRxFrameErr = 3'd3,
    ActTick       = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    KindTx     = 2'd0,
    KindRx     = 2'd1,
    KindStatus = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StChecksum = 2'd1,
    StTimeout  = 2'd2,
    StFraming  = 2'd3
  } status_e;

  // one front request: up to two transmit words, then reply bytes, then status
  typedef struct packed {
    logic            w0_vld;
    logic [8:0]      w0;
    logic            w1_vld;
    logic [8:0]      w1;
    logic [IdxW-1:0] nbytes;
    logic            st_vld;
    status_e         st;
    logic [15:0]     cnt_cs;
    logic [15:0]     cnt_to;
    logic [15:0]     cnt_fr;
  } job_t;

  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] addr;
    logic [7:0]      data;
  } store_wr_t;

endpackage
`default_nettype wire

>>> src/mfl_front.sv
`default_nettype none
module mfl_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic [2:0]                   action_i,
  input  wire logic [7:0]                   node_id_i,
  input  wire logic [4:0]                   send_count_i,
  input  wire logic [4:0]                   reply_count_i,
  input  wire logic [8:0]                   data_word_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [mfl_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [mfl_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                         q_full_i,
  input  wire logic                         bytes_done_i,
  output logic                              job_push_o,
  output mfl_pkg::job_t                     job_o,
  output mfl_pkg::store_wr_t                wr_o
);

  logic [15:0] ticks_q;
  logic [7:0]  seed_q;

  logic busy_q, busy_d;
  logic [4:0] send_left_q, send_left_d;
  logic [7:0] send_check_q, send_check_d;
  logic send_done_q, send_done_d;
  logic reply_act_q, reply_act_d;
  logic [mfl_pkg::CntW-1:0] reply_exp_q, reply_exp_d;
  logic [mfl_pkg::CntW-1:0] reply_rcv_q, reply_rcv_d;
  logic [7:0] reply_check_q, reply_check_d;
  logic framing_q, framing_d;
  logic [mfl_pkg::TmoW-1:0] tmo_q, tmo_d;
  mfl_pkg::status_e pend_q, pend_d;
  logic reply_fin_q, reply_fin_d;
  logic [15:0] cnt_cs_q, cnt_cs_d, cnt_to_q, cnt_to_d, cnt_fr_q, cnt_fr_d;
  logic bytes_pend_q, bytes_pend_d;

  logic accept;
  mfl_pkg::job_t job;

  assign full = q_full_i || bytes_pend_q;
  assign accept = push && !full;

  always_comb begin
    logic [7:0]  exp_w;
    logic [22:0] tmo_prod;
    busy_d        = busy_q;
    send_left_d   = send_left_q;
    send_check_d  = send_check_q;
    send_done_d   = send_done_q;
    reply_act_d   = reply_act_q;
    reply_exp_d   = reply_exp_q;
    reply_rcv_d   = reply_rcv_q;
    reply_check_d = reply_check_q;
    framing_d     = framing_q;
    tmo_d         = tmo_q;
    pend_d        = pend_q;
    reply_fin_d   = reply_fin_q;
    cnt_cs_d      = cnt_cs_q;
    cnt_to_d      = cnt_to_q;
    cnt_fr_d      = cnt_fr_q;
    job           = '0;
    wr_o          = '0;
    exp_w         = {3'b000, reply_count_i} + 8'd1;
    if (exp_w > 8'(mfl_pkg::FrameDepth)) begin
      exp_w = 8'(mfl_pkg::FrameDepth);
    end
    tmo_prod = 23'(ticks_q) * 23'(exp_w);

    if (accept) begin
      unique case (action_i)
        mfl_pkg::ActStart: begin
          if (!busy_q) begin
            busy_d       = 1'b1;
            job.w0_vld   = 1'b1;
            job.w0       = {1'b1, node_id_i};
            send_check_d = node_id_i ^ seed_q;
            send_left_d  = send_count_i;
            send_done_d  = (send_count_i == 5'd0);
            if (send_count_i == 5'd0) begin
              job.w1_vld = 1'b1;
              job.w1     = {1'b0, node_id_i ^ seed_q};
            end
            pend_d = mfl_pkg::StOk;
            if (reply_count_i >= 5'd2) begin
              reply_exp_d   = mfl_pkg::CntW'(exp_w);
              reply_act_d   = 1'b1;
              reply_fin_d   = 1'b0;
              reply_rcv_d   = '0;
              reply_check_d = node_id_i;
              framing_d     = 1'b0;
              tmo_d         = tmo_prod[mfl_pkg::TmoW-1:0];
            end else begin
              reply_act_d = 1'b0;
              reply_fin_d = 1'b1;
            end
            if (send_done_d && reply_fin_d) begin
              job.st_vld = 1'b1;
              job.st     = pend_d;
              busy_d     = 1'b0;
            end
          end
        end
        mfl_pkg::ActTxByte: begin
          if (busy_q && !send_done_q) begin
            job.w0_vld   = 1'b1;
            job.w0       = {1'b0, data_word_i[7:0]};
            send_check_d = send_check_q ^ data_word_i[7:0];
            send_left_d  = send_left_q - 5'd1;
            if (send_left_d == 5'd0) begin
              job.w1_vld  = 1'b1;
              job.w1      = {1'b0, send_check_d};
              send_done_d = 1'b1;
            end
            if (send_done_d && reply_fin_q) begin
              job.st_vld = 1'b1;
              job.st     = pend_q;
              busy_d     = 1'b0;
            end
          end
        end
        mfl_pkg::ActRxWord: begin
          if (reply_act_q) begin
            if (reply_rcv_q < mfl_pkg::CntW'(mfl_pkg::FrameDepth)) begin
              wr_o.en   = 1'b1;
              wr_o.addr = reply_rcv_q[mfl_pkg::IdxW-1:0];
              wr_o.data = data_word_i[7:0];
            end
            reply_check_d = reply_check_q ^ data_word_i[7:0];
            reply_rcv_d   = reply_rcv_q + mfl_pkg::CntW'(1);
            if (reply_rcv_d >= reply_exp_q) begin
              if (framing_q) begin
                pend_d = mfl_pkg::StFraming;
              end else if (reply_check_d == seed_q) begin
                job.nbytes = mfl_pkg::IdxW'(reply_exp_q - mfl_pkg::CntW'(1));
                pend_d     = mfl_pkg::StOk;
              end else begin
                cnt_cs_d = cnt_cs_q + 16'd1;
                pend_d   = mfl_pkg::StChecksum;
              end
              reply_act_d = 1'b0;
              reply_fin_d = 1'b1;
              if (busy_q && send_done_q) begin
                job.st_vld = 1'b1;
                job.st     = pend_d;
                busy_d     = 1'b0;
              end
            end
          end
        end
        mfl_pkg::ActRxFrameErr: begin
          cnt_fr_d = cnt_fr_q + 16'd1;
          if (reply_act_q) begin
            framing_d = 1'b1;
          end
        end
        mfl_pkg::ActTick: begin
          if (reply_act_q) begin
            if (tmo_q <= mfl_pkg::TmoW'(1)) begin
              tmo_d       = '0;
              cnt_to_d    = cnt_to_q + 16'd1;
              reply_act_d = 1'b0;
              reply_fin_d = 1'b1;
              pend_d      = mfl_pkg::StTimeout;
              if (busy_q && send_done_q) begin
                job.st_vld = 1'b1;
                job.st     = pend_d;
                busy_d     = 1'b0;
              end
            end else begin
              tmo_d = tmo_q - mfl_pkg::TmoW'(1);
            end
          end
        end
        default: ;
      endcase
    end

    job.cnt_cs = cnt_cs_d;
    job.cnt_to = cnt_to_d;
    job.cnt_fr = cnt_fr_d;
    job_push_o = accept && (job.w0_vld || job.st_vld || (job.nbytes != '0));
    job_o      = job;

    bytes_pend_d = bytes_pend_q;
    if (job_push_o && (job.nbytes != '0)) begin
      bytes_pend_d = 1'b1;
    end else if (bytes_done_i) begin
      bytes_pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q       <= 16'd88;
      seed_q        <= 8'hAA;
      busy_q        <= 1'b0;
      send_left_q   <= '0;
      send_check_q  <= '0;
      send_done_q   <= 1'b1;
      reply_act_q   <= 1'b0;
      reply_exp_q   <= '0;
      reply_rcv_q   <= '0;
      reply_check_q <= '0;
      framing_q     <= 1'b0;
      tmo_q         <= '0;
      pend_q        <= mfl_pkg::StOk;
      reply_fin_q   <= 1'b1;
      cnt_cs_q      <= '0;
      cnt_to_q      <= '0;
      cnt_fr_q      <= '0;
      bytes_pend_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          mfl_pkg::CfgTimeout: ticks_q <= cfg_data_i;
          mfl_pkg::CfgSeed:    seed_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      busy_q        <= busy_d;
      send_left_q   <= send_left_d;
      send_check_q  <= send_check_d;
      send_done_q   <= send_done_d;
      reply_act_q   <= reply_act_d;
      reply_exp_q   <= reply_exp_d;
      reply_rcv_q   <= reply_rcv_d;
      reply_check_q <= reply_check_d;
      framing_q     <= framing_d;
      tmo_q         <= tmo_d;
      pend_q        <= pend_d;
      reply_fin_q   <= reply_fin_d;
      cnt_cs_q      <= cnt_cs_d;
      cnt_to_q      <= cnt_to_d;
      cnt_fr_q      <= cnt_fr_d;
      bytes_pend_q  <= bytes_pend_d;
    end
  end

endmodule
`default_nettype wire

>>> src/mfl_queue.sv
`default_nettype none
module mfl_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  mfl_pkg::job_t      data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output mfl_pkg::job_t      data_o,
  output logic               empty_o
);

  mfl_pkg::job_t slot_q [mfl_pkg::QDepth];
  logic [mfl_pkg::QPtrW-1:0] wptr_q, rptr_q;
  logic [mfl_pkg::QCntW-1:0] cnt_q;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == mfl_pkg::QCntW'(mfl_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = slot_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + mfl_pkg::QPtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= rptr_q + mfl_pkg::QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + mfl_pkg::QCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - mfl_pkg::QCntW'(1);
      end
    end
  end

endmodule
`default_nettype wire

>>> src/mfl_back.sv
`default_nettype none
module mfl_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  mfl_pkg::job_t      job_i,
  input  wire logic          q_empty_i,
  output logic               q_pop_o,
  input  mfl_pkg::store_wr_t wr_i,
  output logic               bytes_done_o,
  output logic               empty,
  input  wire logic          pop,
  output logic [1:0]         kind_o,
  output logic [8:0]         word_o,
  output logic [1:0]         status_o,
  output logic [15:0]        checksum_errors_o,
  output logic [15:0]        timeout_errors_o,
  output logic [15:0]        framing_errors_o,
  output logic               last_o
);

  typedef enum logic [5:0] {
    BkIdle = 6'b000001,
    BkW0   = 6'b000010,
    BkW1   = 6'b000100,
    BkRd   = 6'b001000,
    BkByte = 6'b010000,
    BkStat = 6'b100000
  } bk_state_e;

  bk_state_e state_q, state_d;
  mfl_pkg::job_t job_q;
  logic [mfl_pkg::IdxW-1:0] idx_q, idx_d;
  logic [7:0] store [mfl_pkg::FrameDepth];
  logic [7:0] mem_q;

  logic out_vld_q, out_vld_d;
  mfl_pkg::kind_e kind_q, kind_d;
  logic [8:0] word_q, word_d;
  mfl_pkg::status_e st_q, st_d;
  logic [15:0] cs_q, cs_d, to_q, to_d, fr_q, fr_d;
  logic last_q, last_d;

  logic slot_free, load, last_byte;
  bk_state_e after_w0, after_w1, after_bytes, first_st;

  assign slot_free = !out_vld_q || pop;
  assign last_byte = (idx_q == job_q.nbytes - mfl_pkg::IdxW'(1));
  assign bytes_done_o = (state_q == BkRd) && last_byte;
  assign q_pop_o = (state_q == BkIdle) && !q_empty_i;

  assign after_bytes = job_q.st_vld ? BkStat : BkIdle;
  assign after_w1 = (job_q.nbytes != '0) ? BkRd : after_bytes;
  assign after_w0 = job_q.w1_vld ? BkW1 : after_w1;

  always_comb begin
    if (job_i.w0_vld) begin
      first_st = BkW0;
    end else if (job_i.nbytes != '0) begin
      first_st = BkRd;
    end else begin
      first_st = BkStat;
    end
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    load    = 1'b0;
    kind_d  = kind_q;
    word_d  = word_q;
    st_d    = st_q;
    last_d  = last_q;
    unique case (state_q)
      BkIdle: begin
        if (!q_empty_i) begin
          state_d = first_st;
          idx_d   = '0;
        end
      end
      BkW0: begin
        if (slot_free) begin
          load    = 1'b1;
          kind_d  = mfl_pkg::KindTx;
          word_d  = job_q.w0;
          st_d    = mfl_pkg::StOk;
          last_d  = (after_w0 == BkIdle);
          state_d = after_w0;
        end
      end
      BkW1: begin
        if (slot_free) begin
          load    = 1'b1;
          kind_d  = mfl_pkg::KindTx;
          word_d  = job_q.w1;
          st_d    = mfl_pkg::StOk;
          last_d  = (after_w1 == BkIdle);
          state_d = after_w1;
        end
      end
      BkRd: begin
        state_d = BkByte;
      end
      BkByte: begin
        if (slot_free) begin
          load   = 1'b1;
          kind_d = mfl_pkg::KindRx;
          word_d = {1'b0, mem_q};
          st_d   = mfl_pkg::StOk;
          last_d = last_byte && !job_q.st_vld;
          idx_d  = idx_q + mfl_pkg::IdxW'(1);
          state_d = last_byte ? after_bytes : BkRd;
        end
      end
      BkStat: begin
        if (slot_free) begin
          load    = 1'b1;
          kind_d  = mfl_pkg::KindStatus;
          word_d  = '0;
          st_d    = job_q.st;
          last_d  = 1'b1;
          state_d = BkIdle;
        end
      end
      default: state_d = BkIdle;
    endcase
    cs_d = load ? job_q.cnt_cs : cs_q;
    to_d = load ? job_q.cnt_to : to_q;
    fr_d = load ? job_q.cnt_fr : fr_q;
    if (load) begin
      out_vld_d = 1'b1;
    end else if (pop) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      store[wr_i.addr] <= wr_i.data;
    end
    if (state_q == BkRd) begin
      mem_q <= store[idx_q];
    end
    if (q_pop_o) begin
      job_q <= job_i;
    end
    kind_q <= kind_d;
    word_q <= word_d;
    st_q   <= st_d;
    cs_q   <= cs_d;
    to_q   <= to_d;
    fr_q   <= fr_d;
    last_q <= last_d;
    idx_q  <= idx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BkIdle;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign empty             = !out_vld_q;
  assign kind_o            = kind_q;
  assign word_o            = word_q;
  assign status_o          = st_q;
  assign checksum_errors_o = cs_q;
  assign timeout_errors_o  = to_q;
  assign framing_errors_o  = fr_q;
  assign last_o            = last_q;

endmodule
`default_nettype wire

>>> src/multidrop_frame_link_controller.sv
// Master side of a 9-bit multidrop serial transaction with XOR checksum.
// Events (start, transmit byte, received word, framing error, timer tick)
// are pushed one per cycle while full is low; the front classifies each one
// and updates the transaction state in that cycle, then hands a request to
// a two-entry queue. The back takes each request from the queue in its idle
// state, then turns it into results: each transmit word or status is loaded
// into the output register, and each reply byte passes through a read state
// and a byte state because it comes through a registered read of the
// 32-entry reply store. While a checked reply's bytes are still being read
// out, full stays high and holds the input. Full also rises when the queue
// fills because the result side is not popping. Configuration writes take
// effect at once and should be made only when no transaction is in flight.
`default_nettype none
module multidrop_frame_link_controller (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic [2:0]                   action_i,
  input  wire logic [7:0]                   node_id_i,
  input  wire logic [4:0]                   send_count_i,
  input  wire logic [4:0]                   reply_count_i,
  input  wire logic [8:0]                   data_word_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [mfl_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [mfl_pkg::CfgDataW-1:0] cfg_data_i,
  output logic                              empty,
  input  wire logic                         pop,
  output logic [1:0]                        kind_o,
  output logic [8:0]                        word_o,
  output logic [1:0]                        status_o,
  output logic [15:0]                       checksum_errors_o,
  output logic [15:0]                       timeout_errors_o,
  output logic [15:0]                       framing_errors_o,
  output logic                              last_o
);

  logic q_full, q_empty, q_pop, job_push, bytes_done;
  mfl_pkg::job_t job_in, job_out;
  mfl_pkg::store_wr_t wr;

  mfl_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .action_i      (action_i),
    .node_id_i     (node_id_i),
    .send_count_i  (send_count_i),
    .reply_count_i (reply_count_i),
    .data_word_i   (data_word_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .q_full_i      (q_full),
    .bytes_done_i  (bytes_done),
    .job_push_o    (job_push),
    .job_o         (job_in),
    .wr_o          (wr)
  );

  mfl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (job_out),
    .empty_o (q_empty)
  );

  mfl_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .job_i             (job_out),
    .q_empty_i         (q_empty),
    .q_pop_o           (q_pop),
    .wr_i              (wr),
    .bytes_done_o      (bytes_done),
    .empty             (empty),
    .pop               (pop),
    .kind_o            (kind_o),
    .word_o            (word_o),
    .status_o          (status_o),
    .checksum_errors_o (checksum_errors_o),
    .timeout_errors_o  (timeout_errors_o),
    .framing_errors_o  (framing_errors_o),
    .last_o            (last_o)
  );

endmodule
`default_nettype wire

>>> verif/multidrop_frame_link_controller_test.sv
`default_nettype none
module multidrop_frame_link_controller_test;

  localparam int FrameClean   = 0;
  localparam int FrameBadSum  = 1;
  localparam int FrameFraming = 2;
  localparam int FrameTimeout = 3;

  typedef struct packed {
    mfl_pkg::kind_e   kind;
    logic [8:0]       word;
    mfl_pkg::status_e st;
    logic [15:0]      cs;
    logic [15:0]      tmo;
    logic [15:0]      frm;
    logic             last;
  } link_result_t;

  logic                         clk;
  logic                         rst_ni;
  logic                         push;
  logic                         full;
  logic [2:0]                   action;
  logic [7:0]                   node_id;
  logic [4:0]                   send_count;
  logic [4:0]                   reply_count;
  logic [8:0]                   data_word;
  logic                         cfg_we;
  logic [mfl_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [mfl_pkg::CfgDataW-1:0] cfg_data;
  logic                         empty;
  logic                         pop = 1'b0;
  logic [1:0]                   kind;
  logic [8:0]                   word;
  logic [1:0]                   status;
  logic [15:0]                  checksum_errors;
  logic [15:0]                  timeout_errors;
  logic [15:0]                  framing_errors;
  logic                         last;

  multidrop_frame_link_controller u_top (
    .clk_i             (clk),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .action_i          (action),
    .node_id_i         (node_id),
    .send_count_i      (send_count),
    .reply_count_i     (reply_count),
    .data_word_i       (data_word),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_data_i        (cfg_data),
    .empty             (empty),
    .pop               (pop),
    .kind_o            (kind),
    .word_o            (word),
    .status_o          (status),
    .checksum_errors_o (checksum_errors),
    .timeout_errors_o  (timeout_errors),
    .framing_errors_o  (framing_errors),
    .last_o            (last)
  );

  // link model state
  logic [15:0]      cfg_ticks = 16'd88;
  logic [7:0]       cfg_seed = 8'd170;
  logic             txn_busy = 1'b0;
  logic [4:0]       tx_left = '0;
  logic [7:0]       tx_sum = '0;
  logic             tx_done = 1'b1;
  logic             rx_wait = 1'b0;
  logic [5:0]       rx_expect = '0;
  logic [5:0]       rx_got = '0;
  logic [7:0]       rx_sum = '0;
  logic             rx_framing = 1'b0;
  logic [7:0]       rx_bytes [mfl_pkg::FrameDepth];
  logic [20:0]      rx_ticks_left = '0;
  mfl_pkg::status_e txn_status = mfl_pkg::StOk;
  logic             rx_done = 1'b1;
  logic [15:0]      n_cs = '0;
  logic [15:0]      n_to = '0;
  logic [15:0]      n_fr = '0;

  link_result_t burst_buf [40];
  int           burst_n;
  link_result_t exp_q [$];

  bit drive_idle = 1'b1;
  bit pop_idle = 1'b1;
  int pop_pause = 0;
  int bad_results = 0;
  int live_items = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("multidrop_frame_link_controller_test failed");
    $finish;
  end

  function automatic void add_result(mfl_pkg::kind_e k, logic [8:0] w, mfl_pkg::status_e s);
    link_result_t r;
    r.kind = k;
    r.word = w;
    r.st   = s;
    r.cs   = n_cs;
    r.tmo  = n_to;
    r.frm  = n_fr;
    r.last = 1'b0;
    burst_buf[burst_n] = r;
    burst_n++;
  endfunction

  function automatic void try_close();
    if (txn_busy && tx_done && rx_done) begin
      add_result(mfl_pkg::KindStatus, 9'd0, txn_status);
      txn_busy = 1'b0;
    end
  endfunction

  function automatic void finish_reply();
    int i;
    if (rx_framing) begin
      txn_status = mfl_pkg::StFraming;
    end else if (rx_sum == cfg_seed) begin
      for (i = 0; i + 1 < rx_expect; i++)
        add_result(mfl_pkg::KindRx, {1'b0, rx_bytes[i]}, mfl_pkg::StOk);
      txn_status = mfl_pkg::StOk;
    end else begin
      n_cs++;
      txn_status = mfl_pkg::StChecksum;
    end
    rx_wait = 1'b0;
    rx_done = 1'b1;
  endfunction

  // returns 1 when the event changed the link state
  function automatic bit predict_link(logic [2:0] act, logic [7:0] node, logic [4:0] sc,
                                      logic [4:0] rc, logic [8:0] dw);
    bit          took;
    int unsigned span;
    int          i;
    took = 1'b0;
    burst_n = 0;
    case (act)
      mfl_pkg::ActStart: begin
        if (!txn_busy) begin
          took = 1'b1;
          txn_busy = 1'b1;
          add_result(mfl_pkg::KindTx, {1'b1, node}, mfl_pkg::StOk);
          tx_sum = node ^ cfg_seed;
          tx_left = sc;
          tx_done = 1'b0;
          if (tx_left == 5'd0) begin
            add_result(mfl_pkg::KindTx, {1'b0, tx_sum}, mfl_pkg::StOk);
            tx_done = 1'b1;
          end
          txn_status = mfl_pkg::StOk;
          if (rc >= 5'd2) begin
            span = rc + 1;
            if (span > mfl_pkg::FrameDepth) span = mfl_pkg::FrameDepth;
            rx_expect = 6'(span);
            rx_wait = 1'b1;
            rx_done = 1'b0;
            rx_got = '0;
            rx_sum = node;
            rx_framing = 1'b0;
            span = cfg_ticks;
            span = span * rx_expect;
            rx_ticks_left = span[20:0];
          end else begin
            rx_wait = 1'b0;
            rx_done = 1'b1;
          end
          try_close();
        end
      end
      mfl_pkg::ActTxByte: begin
        if (txn_busy && !tx_done) begin
          took = 1'b1;
          add_result(mfl_pkg::KindTx, {1'b0, dw[7:0]}, mfl_pkg::StOk);
          tx_sum = tx_sum ^ dw[7:0];
          tx_left = tx_left - 5'd1;
          if (tx_left == 5'd0) begin
            add_result(mfl_pkg::KindTx, {1'b0, tx_sum}, mfl_pkg::StOk);
            tx_done = 1'b1;
          end
          try_close();
        end
      end
      mfl_pkg::ActRxWord: begin
        if (rx_wait) begin
          took = 1'b1;
          if (rx_got < mfl_pkg::FrameDepth) rx_bytes[rx_got] = dw[7:0];
          rx_sum = rx_sum ^ dw[7:0];
          rx_got++;
          if (rx_got >= rx_expect) begin
            finish_reply();
            try_close();
          end
        end
      end
      mfl_pkg::ActRxFrameErr: begin
        took = 1'b1;
        n_fr++;
        if (rx_wait) rx_framing = 1'b1;
      end
      mfl_pkg::ActTick: begin
        if (rx_wait) begin
          took = 1'b1;
          if (rx_ticks_left <= 21'd1) begin
            rx_ticks_left = '0;
            n_to++;
            rx_wait = 1'b0;
            rx_done = 1'b1;
            txn_status = mfl_pkg::StTimeout;
            try_close();
          end else begin
            rx_ticks_left--;
          end
        end
      end
      default: ;
    endcase
    if (burst_n > 0) burst_buf[burst_n-1].last = 1'b1;
    for (i = 0; i < burst_n; i++) exp_q.push_back(burst_buf[i]);
    return took;
  endfunction

  // result side: random pop stalls, compare against the oldest expectation
  always @(posedge clk) begin
    link_result_t got;
    link_result_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        got.kind = mfl_pkg::kind_e'(kind);
        got.word = word;
        got.st   = mfl_pkg::status_e'(status);
        got.cs   = checksum_errors;
        got.tmo  = timeout_errors;
        got.frm  = framing_errors;
        got.last = last;
        if (exp_q.size() == 0) begin
          bad_results++;
          if (bad_results <= 10)
            $display("unexpected result: kind %0d word %h status %0d last %0b",
                     kind, word, status, last);
        end else begin
          want = exp_q.pop_front();
          if (got !== want) begin
            bad_results++;
            if (bad_results <= 10) begin
              $display("mismatch exp: kind %0d word %h st %0d cs %0d to %0d fr %0d last %0b",
                       want.kind, want.word, want.st, want.cs, want.tmo, want.frm, want.last);
              $display("         got: kind %0d word %h st %0d cs %0d to %0d fr %0d last %0b",
                       got.kind, got.word, got.st, got.cs, got.tmo, got.frm, got.last);
            end
          end
        end
        pop_pause = pop_idle ? $urandom_range(0, 6) : 0;
        if (pop_pause > 0) pop <= 1'b0;
      end else if (!pop) begin
        if (pop_pause > 0) pop_pause--;
        if (pop_pause == 0) pop <= 1'b1;
      end
    end
  end

  task automatic send_item(logic [2:0] act, logic [7:0] node, logic [4:0] sc,
                           logic [4:0] rc, logic [8:0] dw);
    int gap;
    gap = drive_idle ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push        <= 1'b1;
    action      <= act;
    node_id     <= node;
    send_count  <= sc;
    reply_count <= rc;
    data_word   <= dw;
    @(posedge clk);
    while (full) @(posedge clk);
    if (predict_link(act, node, sc, rc, dw)) live_items++;
  endtask

  // stray events: ones the block should drop or only count, and timer ticks
  task automatic send_stray(bit in_frame);
    int pick;
    pick = in_frame ? $urandom_range(0, 2) : $urandom_range(0, 4);
    if (in_frame && pick == 2) pick = 5;
    if (pick == 1 && rx_wait && rx_ticks_left <= 21'd1) pick = 0;
    case (pick)
      0: send_item(3'(mfl_pkg::ActTick) + 3'($urandom_range(1, 3)), 8'($urandom),
                   5'($urandom), 5'($urandom), 9'($urandom));
      1: send_item(mfl_pkg::ActTick, 8'($urandom), 5'($urandom), 5'($urandom),
                   9'($urandom));
      2: send_item(mfl_pkg::ActTxByte, 8'($urandom), 5'($urandom), 5'($urandom),
                   9'($urandom));
      3: send_item(mfl_pkg::ActRxWord, 8'($urandom), 5'($urandom), 5'($urandom),
                   9'($urandom));
      4: send_item(mfl_pkg::ActRxFrameErr, 8'($urandom), 5'($urandom), 5'($urandom),
                   9'($urandom));
      default: send_item(mfl_pkg::ActStart, 8'($urandom), 5'($urandom), 5'($urandom),
                         9'($urandom));
    endcase
  endtask

  // one transaction: start, then transmit bytes and reply words interleaved with strays, ticks or a framing error
  task automatic run_frame(logic [7:0] node, logic [4:0] sc, logic [4:0] rc, int mode,
                           int tx_bias);
    logic [8:0]  words [mfl_pkg::FrameDepth];
    logic [7:0]  chk;
    int          nrx;
    int          k;
    int          cut;
    int          roll;
    bit          fr_sent;
    int unsigned budget;
    nrx = 0;
    chk = node ^ cfg_seed;
    if (rc >= 5'd2)
      nrx = (rc + 1 > mfl_pkg::FrameDepth) ? mfl_pkg::FrameDepth : rc + 1;
    for (k = 0; k < nrx - 1; k++) begin
      words[k] = 9'($urandom);
      chk = chk ^ words[k][7:0];
    end
    if (nrx > 0) begin
      if (mode == FrameBadSum) chk = chk ^ (8'd1 << $urandom_range(0, 7));
      words[nrx-1] = {1'($urandom), chk};
    end
    budget = cfg_ticks;
    budget = budget * nrx;
    if (mode == FrameTimeout && budget > 200) mode = FrameClean;
    cut = (nrx > 0) ? $urandom_range(0, nrx - 1) : 0;
    fr_sent = 1'b0;
    k = 0;
    send_item(mfl_pkg::ActStart, node, sc, rc, 9'($urandom));
    while (txn_busy) begin
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
        send_stray(1'b1);
      end else if (!tx_done && (!rx_wait || roll < 6 + 9 * tx_bias)) begin
        send_item(mfl_pkg::ActTxByte, 8'($urandom), 5'($urandom), 5'($urandom),
                  9'($urandom));
      end else if (mode == FrameTimeout && k >= cut) begin
        send_item(mfl_pkg::ActTick, 8'($urandom), 5'($urandom), 5'($urandom),
                  9'($urandom));
      end else if (mode == FrameFraming && k == cut && !fr_sent) begin
        send_item(mfl_pkg::ActRxFrameErr, 8'($urandom), 5'($urandom), 5'($urandom),
                  9'($urandom));
        fr_sent = 1'b1;
      end else begin
        send_item(mfl_pkg::ActRxWord, 8'($urandom), 5'($urandom), 5'($urandom), words[k]);
        k++;
      end
    end
  endtask

  task automatic settle_link();
    push <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(logic [mfl_pkg::CfgIdxW-1:0] idx,
                           logic [mfl_pkg::CfgDataW-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(logic [15:0] ticks, logic [7:0] seed);
    settle_link();
    write_reg(mfl_pkg::CfgTimeout, ticks);
    write_reg(mfl_pkg::CfgSeed, {8'($urandom), seed});
    cfg_ticks = ticks;
    cfg_seed  = seed;
  endtask

  task automatic test_short_frames();
    run_frame(8'h00, 5'd0, 5'd0, FrameClean, 5);
    run_frame(8'hFF, 5'd1, 5'd1, FrameClean, 5);
  endtask

  task automatic test_idle_events();
    logic [2:0] a;
    a = mfl_pkg::ActTxByte;
    do begin
      send_item(a, 8'($urandom), 5'($urandom), 5'($urandom), 9'h1FF);
      a++;
    end while (a != mfl_pkg::ActStart);
  endtask

  task automatic test_busy_start();
    send_item(mfl_pkg::ActStart, 8'h12, 5'd1, 5'd0, 9'd0);
    send_item(mfl_pkg::ActStart, 8'hED, 5'd0, 5'd0, 9'd0);
    send_item(mfl_pkg::ActTxByte, 8'd0, 5'd0, 5'd0, 9'h155);
  endtask

  task automatic test_reply_first();
    run_frame(8'h5A, 5'd2, 5'd2, FrameClean, 0);
  endtask

  task automatic test_reply_errors();
    run_frame(8'h81, 5'd3, 5'd4, FrameBadSum, 5);
    run_frame(8'h7E, 5'd1, 5'd2, FrameFraming, 5);
  endtask

  task automatic test_timeouts();
    set_config(16'd1, 8'h00);
    run_frame(8'h33, 5'd2, 5'd3, FrameTimeout, 3);
    set_config(16'd0, 8'h0F);
    run_frame(8'hC3, 5'd0, 5'd2, FrameTimeout, 5);
  endtask

  task automatic test_long_frames();
    set_config(16'hFFFF, 8'hFF);
    run_frame(8'hA5, 5'd31, 5'd31, FrameClean, 5);
    run_frame(8'h5A, 5'd3, 5'd30, FrameBadSum, 5);
  endtask

  task automatic test_random_traffic();
    int         ph;
    int         first;
    int         roll;
    int         mode;
    logic [4:0] sc;
    logic [4:0] rc;
    for (ph = 0; ph < 4; ph++) begin
      set_config(($urandom_range(0, 9) < 6) ? 16'($urandom_range(0, 4)) : 16'($urandom),
                 8'($urandom));
      drive_idle = ($urandom_range(0, 3) != 0);
      pop_idle   = ($urandom_range(0, 3) != 0);
      first = live_items;
      while (live_items - first < 15) begin
        if ($urandom_range(0, 9) < 8) begin
          sc = ($urandom_range(0, 19) == 0) ? 5'($urandom) : 5'($urandom_range(0, 6));
          rc = ($urandom_range(0, 19) == 0) ? 5'($urandom) : 5'($urandom_range(0, 8));
          roll = $urandom_range(0, 9);
          if (roll < 6) mode = FrameClean;
          else if (roll < 8) mode = FrameBadSum;
          else if (roll < 9) mode = FrameFraming;
          else mode = FrameTimeout;
          run_frame(8'($urandom), sc, rc, mode, $urandom_range(0, 10));
        end else begin
          repeat ($urandom_range(1, 3)) send_stray(1'b0);
        end
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    push        = 1'b0;
    action      = '0;
    node_id     = '0;
    send_count  = '0;
    reply_count = '0;
    data_word   = '0;
    cfg_we      = 1'b0;
    cfg_idx     = '0;
    cfg_data    = '0;
    repeat (9) @(posedge clk);
    rst_ni <= 1'b1;
    test_short_frames();
    test_idle_events();
    test_busy_start();
    test_reply_first();
    test_reply_errors();
    test_timeouts();
    test_long_frames();
    test_random_traffic();
    settle_link();
    if (bad_results == 0 && exp_q.size() == 0)
      $display("multidrop_frame_link_controller_test passed");
    else
      $display("multidrop_frame_link_controller_test failed");
    $finish;
  end

endmodule
`default_nettype wire
